/* sv/irqra_pkg.sv */
package irqra_pkg;

  localparam int MAP_BITS      = 256;
  localparam int INITIAL_LIMIT = 64;
  localparam int WORD_W        = 16;
  localparam int NUM_WORDS     = MAP_BITS / WORD_W;
  localparam int BIT_W         = $clog2(WORD_W);
  localparam int WIDX_W        = $clog2(NUM_WORDS);
  localparam int IDX_W         = 8;
  localparam int LIM_W         = 9;
  localparam int CNT_W         = 9;
  localparam int STS_W         = 2;
  localparam int RESET_LIMIT   = (INITIAL_LIMIT > MAP_BITS) ? MAP_BITS : INITIAL_LIMIT;

  typedef enum logic [1:0] {
    REQ_ALLOC_ANY   = 2'd0,
    REQ_ALLOC_FIXED = 2'd1,
    REQ_FREE        = 2'd2,
    REQ_NEXT        = 2'd3
  } req_e;

  typedef enum logic [STS_W-1:0] {
    RES_OK      = 2'd0,
    RES_INVAL   = 2'd1,
    RES_TAKEN   = 2'd2,
    RES_NOSPACE = 2'd3
  } res_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CHECK,
    CMD_SCAN,
    CMD_WRITE,
    CMD_NEXT,
    CMD_PUBLISH
  } cmd_e;

  typedef struct packed {
    logic chk_scan;
    logic chk_write;
    logic chk_next;
    logic scan_done;
    logic scan_write;
    logic next_done;
    logic write_last;
  } dp_status_t;

endpackage

/* sv/irqra_ctrl.sv */
module irqra_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  irqra_pkg::dp_status_t sts_i,
  output irqra_pkg::cmd_e       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_WRITE,
    S_NEXT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   publish;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign publish     = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cmd_o   = irqra_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = irqra_pkg::CMD_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o = irqra_pkg::CMD_CHECK;
        if (sts_i.chk_scan) begin
          state_d = S_SCAN;
        end else if (sts_i.chk_write) begin
          state_d = S_WRITE;
        end else if (sts_i.chk_next) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o = irqra_pkg::CMD_SCAN;
        if (sts_i.scan_write) begin
          state_d = S_WRITE;
        end else if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_WRITE: begin
        cmd_o = irqra_pkg::CMD_WRITE;
        if (sts_i.write_last) begin
          state_d = S_DONE;
        end
      end
      S_NEXT: begin
        cmd_o = irqra_pkg::CMD_NEXT;
        if (sts_i.next_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (publish) begin
          cmd_o   = irqra_pkg::CMD_PUBLISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (publish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/irqra_dp.sv */
module irqra_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  irqra_pkg::cmd_e              cmd_i,
  input  logic [1:0]                   req_type_i,
  input  logic [irqra_pkg::IDX_W-1:0]  start_hint_i,
  input  logic [irqra_pkg::IDX_W-1:0]  fixed_number_i,
  input  logic [irqra_pkg::CNT_W-1:0]  count_i,
  output irqra_pkg::dp_status_t        sts_o,
  output logic [irqra_pkg::STS_W-1:0]  status_o,
  output logic [irqra_pkg::LIM_W-1:0]  number_o
);

  localparam int WORD_W = irqra_pkg::WORD_W;
  localparam int BIT_W  = irqra_pkg::BIT_W;
  localparam int WIDX_W = irqra_pkg::WIDX_W;
  localparam int IDX_W  = irqra_pkg::IDX_W;
  localparam int LIM_W  = irqra_pkg::LIM_W;
  localparam int CNT_W  = irqra_pkg::CNT_W;

  // bitmap and limit
  logic [WORD_W-1:0]       map_q [irqra_pkg::NUM_WORDS];
  logic [LIM_W-1:0]        limit_q;

  // per-request registers
  irqra_pkg::req_e         req_q;
  logic [IDX_W-1:0]        hint_q;
  logic [IDX_W-1:0]        fixed_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [IDX_W-1:0]        from_q;
  logic [WIDX_W-1:0]       widx_q;
  logic [LIM_W-1:0]        run_q;
  logic [LIM_W-1:0]        lo_q;
  logic [LIM_W-1:0]        hi_q;
  logic                    set_q;
  irqra_pkg::res_e         res_status_q;
  logic [LIM_W-1:0]        res_number_q;
  logic [irqra_pkg::STS_W-1:0] out_status_q;
  logic [LIM_W-1:0]        out_number_q;

  logic [WORD_W-1:0]       word;
  logic [WORD_W-1:0]       occ;
  logic [WORD_W-1:0]       fit;
  logic [WORD_W-1:0]       hit;
  logic [WORD_W-1:0]       mask;
  logic [LIM_W-1:0]        run_len [WORD_W];
  logic                    fnd;
  logic [BIT_W-1:0]        fpos;
  logic                    hit_any;
  logic [BIT_W-1:0]        hpos;
  logic [LIM_W:0]          start_ext;
  logic [IDX_W-1:0]        fstart;
  logic [LIM_W-1:0]        fend;
  logic [LIM_W-1:0]        word_end;
  logic [LIM_W-1:0]        hi_m1;
  logic [LIM_W:0]          free_end;
  logic                    is_alloc;
  logic                    is_fixed;
  logic                    alloc_bad;
  logic                    free_bad;
  logic                    last_word;
  logic                    fixed_miss;

  assign word      = map_q[widx_q];
  assign is_alloc  = (req_q == irqra_pkg::REQ_ALLOC_ANY) || (req_q == irqra_pkg::REQ_ALLOC_FIXED);
  assign is_fixed  = (req_q == irqra_pkg::REQ_ALLOC_FIXED);
  assign alloc_bad = (cnt_q == '0) || (is_fixed && (hint_q > fixed_q));
  assign free_end  = {2'b00, hint_q} + {1'b0, cnt_q};
  assign free_bad  = ({1'b0, hint_q} >= limit_q) || (free_end > {1'b0, limit_q});
  assign last_word = (widx_q == WIDX_W'(irqra_pkg::NUM_WORDS - 1));
  assign word_end  = {1'b0, widx_q, {BIT_W{1'b0}}} + LIM_W'(WORD_W);
  assign hi_m1     = hi_q - LIM_W'(1);

  // run length of free numbers ending at each bit of the current word
  always_comb begin
    logic             has;
    logic [BIT_W-1:0] last;
    for (int p = 0; p < WORD_W; p++) begin
      occ[p] = word[p] || ({widx_q, BIT_W'(p)} < from_q);
    end
    for (int p = 0; p < WORD_W; p++) begin
      has  = 1'b0;
      last = '0;
      for (int q = 0; q <= p; q++) begin
        if (occ[q]) begin
          has  = 1'b1;
          last = BIT_W'(q);
        end
      end
      if (has) begin
        run_len[p] = LIM_W'(BIT_W'(p) - last);
      end else begin
        run_len[p] = run_q + LIM_W'(p) + LIM_W'(1);
      end
      fit[p] = (run_len[p] >= cnt_q);
    end
  end

  always_comb begin
    fnd     = |fit;
    fpos    = '0;
    hit_any = |hit;
    hpos    = '0;
    for (int p = WORD_W - 1; p >= 0; p--) begin
      if (fit[p]) begin
        fpos = BIT_W'(p);
      end
      if (hit[p]) begin
        hpos = BIT_W'(p);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < WORD_W; p++) begin
      hit[p]  = word[p] && ({widx_q, BIT_W'(p)} >= hint_q) &&
                ({1'b0, widx_q, BIT_W'(p)} < limit_q);
      mask[p] = ({1'b0, widx_q, BIT_W'(p)} >= lo_q) &&
                ({1'b0, widx_q, BIT_W'(p)} < hi_q);
    end
  end

  assign start_ext  = {2'b00, widx_q, fpos} + (LIM_W + 1)'(1) - {1'b0, cnt_q};
  assign fstart     = start_ext[IDX_W-1:0];
  assign fend       = {1'b0, fstart} + cnt_q;
  assign fixed_miss = is_fixed && (fstart != fixed_q);

  always_comb begin
    sts_o.chk_scan   = is_alloc && !alloc_bad;
    sts_o.chk_write  = (req_q == irqra_pkg::REQ_FREE) && !free_bad && (cnt_q != '0);
    sts_o.chk_next   = (req_q == irqra_pkg::REQ_NEXT);
    sts_o.scan_done  = fnd || last_word;
    sts_o.scan_write = fnd && !fixed_miss;
    sts_o.next_done  = hit_any || (word_end >= limit_q) || last_word;
    sts_o.write_last = (widx_q == hi_m1[IDX_W-1:BIT_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < irqra_pkg::NUM_WORDS; w++) begin
        map_q[w] <= '0;
      end
      limit_q <= LIM_W'(irqra_pkg::RESET_LIMIT);
    end else begin
      if (cmd_i == irqra_pkg::CMD_WRITE) begin
        map_q[widx_q] <= set_q ? (word | mask) : (word & ~mask);
      end
      if ((cmd_i == irqra_pkg::CMD_SCAN) && fnd && !fixed_miss && (fend > limit_q)) begin
        limit_q <= fend;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      irqra_pkg::CMD_LOAD: begin
        req_q   <= irqra_pkg::req_e'(req_type_i);
        hint_q  <= start_hint_i;
        fixed_q <= fixed_number_i;
        cnt_q   <= count_i;
      end
      irqra_pkg::CMD_CHECK: begin
        res_status_q <= irqra_pkg::RES_OK;
        res_number_q <= '0;
        run_q        <= '0;
        widx_q       <= hint_q[IDX_W-1:BIT_W];
        lo_q         <= {1'b0, hint_q};
        hi_q         <= free_end[LIM_W-1:0];
        set_q        <= 1'b0;
        from_q       <= hint_q;
        if (is_alloc) begin
          if (alloc_bad) begin
            res_status_q <= irqra_pkg::RES_INVAL;
          end
          if (is_fixed) begin
            from_q <= fixed_q;
            widx_q <= fixed_q[IDX_W-1:BIT_W];
          end
        end else if (req_q == irqra_pkg::REQ_FREE) begin
          if (free_bad) begin
            res_status_q <= irqra_pkg::RES_INVAL;
          end
        end else begin
          res_number_q <= limit_q;
        end
      end
      irqra_pkg::CMD_SCAN: begin
        if (fnd) begin
          lo_q   <= {1'b0, fstart};
          hi_q   <= fend;
          widx_q <= fstart[IDX_W-1:BIT_W];
          set_q  <= 1'b1;
          if (fixed_miss) begin
            res_status_q <= irqra_pkg::RES_TAKEN;
          end else begin
            res_status_q <= irqra_pkg::RES_OK;
            res_number_q <= {1'b0, fstart};
          end
        end else begin
          run_q  <= run_len[WORD_W-1];
          widx_q <= widx_q + WIDX_W'(1);
          if (last_word) begin
            res_status_q <= is_fixed ? irqra_pkg::RES_TAKEN : irqra_pkg::RES_NOSPACE;
          end
        end
      end
      irqra_pkg::CMD_WRITE: begin
        widx_q <= widx_q + WIDX_W'(1);
      end
      irqra_pkg::CMD_NEXT: begin
        if (hit_any) begin
          res_number_q <= {1'b0, widx_q, hpos};
        end else begin
          widx_q <= widx_q + WIDX_W'(1);
        end
      end
      irqra_pkg::CMD_PUBLISH: begin
        out_status_q <= res_status_q;
        out_number_q <= res_number_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o = out_status_q;
  assign number_o = out_number_q;

endmodule

/* sv/irq_number_range_allocator.sv */
// Interrupt number range allocator over a 256-entry bitmap held as 16 words
// of 16 bits, with a limit that only grows. One request is in work at a time;
// the bitmap is walked one word per cycle by a single scan unit. A request
// is loaded and checked, then scans up to 16 words for an allocation or a
// next-number search, and for an allocation or free that changes the map
// writes up to 16 words before it is published. A finished result sits in
// the output register while the next request is taken in. The bitmap is cleared by reset, no sweep needed.
module irq_number_range_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [irqra_pkg::IDX_W-1:0]  start_hint_i,
  input  logic [irqra_pkg::IDX_W-1:0]  fixed_number_i,
  input  logic [irqra_pkg::CNT_W-1:0]  count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [irqra_pkg::STS_W-1:0]  status_o,
  output logic [irqra_pkg::LIM_W-1:0]  number_o
);

  irqra_pkg::cmd_e       cmd;
  irqra_pkg::dp_status_t sts;

  irqra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  irqra_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_type_i),
    .start_hint_i   (start_hint_i),
    .fixed_number_i (fixed_number_i),
    .count_i        (count_i),
    .sts_o          (sts),
    .status_o       (status_o),
    .number_o       (number_o)
  );

endmodule
